@@ rtl/cpsp_pkg.sv @@
// Shared widths, codes, controller/datapath interface types and saturation helpers.
package cpsp_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int DEADBAND_DEG = 3;

    localparam int DATA_W     = 32;
    localparam int RPM_W      = 16;
    localparam int INT_W      = 48;
    localparam int LIM_W      = 31;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    // gain products: operand magnitude split at SPLIT bits, two passes of one multiplier
    localparam int OPND_W = 50;
    localparam int MAG_W  = 49;
    localparam int SPLIT  = 24;
    localparam int UP     = SPLIT - FRAC_BITS;
    localparam int HI_W   = MAG_W - SPLIT;
    localparam int PROD_W = DATA_W + HI_W;
    localparam int TSUM_W = 49;
    localparam int ACC_W  = 51;

    localparam logic [TSUM_W-1:0] TERM_LIM = TSUM_W'((64'd1 << (INT_W - 1)) - 64'd1);
    localparam logic [PROD_W-1:0] P_LIM    = PROD_W'(TERM_LIM >> UP);
    localparam logic [DATA_W:0]   DB_LIM   = (DATA_W + 1)'(DEADBAND_DEG) << FRAC_BITS;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POS_KP      = 4'd0,
        REG_POS_KI      = 4'd1,
        REG_POS_KD      = 4'd2,
        REG_POS_OUT_MAX = 4'd3,
        REG_SPD_KP      = 4'd4,
        REG_SPD_KI      = 4'd5,
        REG_SPD_KD      = 4'd6,
        REG_SPD_OUT_MAX = 4'd7
    } t_cfg_reg;

    typedef enum logic [2:0] {
        TERM_POS_P,
        TERM_POS_I,
        TERM_POS_D,
        TERM_SPD_P,
        TERM_SPD_I,
        TERM_SPD_D
    } t_term;

    typedef struct packed {
        logic  load_in;
        logic  calc_err;
        logic  load_opnd;
        logic  mul_hi;
        logic  mul_lo;
        logic  acc;
        logic  calc_sref;
        logic  commit;
        t_term term;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_sts;

    function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [OPND_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if ((&v[OPND_W-1:DATA_W-1]) || !(|v[OPND_W-1:DATA_W-1])) begin
            r = v[DATA_W-1:0];
        end else if (v[OPND_W-1]) begin
            r = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(DATA_W-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic logic signed [INT_W-1:0] sat_int(input logic signed [OPND_W-1:0] v);
        logic signed [INT_W-1:0] r;
        if ((&v[OPND_W-1:INT_W-1]) || !(|v[OPND_W-1:INT_W-1])) begin
            r = v[INT_W-1:0];
        end else if (v[OPND_W-1]) begin
            r = {1'b1, {(INT_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(INT_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

@@ rtl/cpsp_ctrl.sv @@
// Sequencer: walks the datapath through error, six gain terms, clamp and commit.
module cpsp_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  cpsp_pkg::t_dp_sts  i_sts,
    output cpsp_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ERR,
        S_OPND,
        S_MHI,
        S_MLO,
        S_ACC,
        S_SREF,
        S_FIN
    } t_state;

    t_state          r_state, n_state;
    cpsp_pkg::t_term r_term,  n_term;

    always_comb begin
        n_state = r_state;
        n_term  = r_term;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_ERR;
            end
            S_ERR: begin
                n_term  = cpsp_pkg::TERM_POS_P;
                n_state = S_OPND;
            end
            S_OPND: n_state = S_MHI;
            S_MHI:  n_state = S_MLO;
            S_MLO:  n_state = S_ACC;
            S_ACC: begin
                n_state = S_OPND;
                unique case (r_term)
                    cpsp_pkg::TERM_POS_P: n_term = cpsp_pkg::TERM_POS_I;
                    cpsp_pkg::TERM_POS_I: n_term = cpsp_pkg::TERM_POS_D;
                    cpsp_pkg::TERM_POS_D: n_state = S_SREF;
                    cpsp_pkg::TERM_SPD_P: n_term = cpsp_pkg::TERM_SPD_I;
                    cpsp_pkg::TERM_SPD_I: n_term = cpsp_pkg::TERM_SPD_D;
                    cpsp_pkg::TERM_SPD_D: n_state = S_FIN;
                    default:              n_state = S_FIN;
                endcase
            end
            S_SREF: begin
                n_term  = cpsp_pkg::TERM_SPD_P;
                n_state = S_OPND;
            end
            S_FIN: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_term  <= cpsp_pkg::TERM_POS_P;
        end else begin
            r_state <= n_state;
            r_term  <= n_term;
        end
    end

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        o_cmd           = '0;
        o_cmd.term      = r_term;
        o_cmd.load_in   = (r_state == S_IDLE) && i_valid;
        o_cmd.calc_err  = (r_state == S_ERR);
        o_cmd.load_opnd = (r_state == S_OPND);
        o_cmd.mul_hi    = (r_state == S_MHI);
        o_cmd.mul_lo    = (r_state == S_MLO);
        o_cmd.acc       = (r_state == S_ACC);
        o_cmd.calc_sref = (r_state == S_SREF);
        o_cmd.commit    = (r_state == S_FIN) && i_sts.out_free;
    end

endmodule

@@ rtl/cpsp_dp.sv @@
// Datapath: gain registers, loop state, shared gain multiplier, clamps and output register.
module cpsp_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  cpsp_pkg::t_dp_cmd                      i_cmd,
    output cpsp_pkg::t_dp_sts                      o_sts,
    input  logic                                   i_cfg_we,
    input  logic [cpsp_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [cpsp_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic signed [cpsp_pkg::DATA_W-1:0]     i_pos_target,
    input  logic signed [cpsp_pkg::DATA_W-1:0]     i_pos_feedback,
    input  logic signed [cpsp_pkg::RPM_W-1:0]      i_speed_feedback,
    input  logic                                   i_stall,
    output logic                                   o_valid,
    output logic signed [cpsp_pkg::DATA_W-1:0]     o_speed_reference,
    output logic signed [cpsp_pkg::DATA_W-1:0]     o_drive_command,
    output logic                                   o_in_deadband
);

    localparam int DW = cpsp_pkg::DATA_W;
    localparam int OW = cpsp_pkg::OPND_W;
    localparam int AW = cpsp_pkg::ACC_W;

    // gains and limits
    logic [DW-1:0]                 r_pos_kp, r_pos_ki, r_pos_kd;
    logic [DW-1:0]                 r_spd_kp, r_spd_ki, r_spd_kd;
    logic [cpsp_pkg::LIM_W-1:0]    r_pos_out_max, r_spd_out_max;

    // loop state
    logic signed [cpsp_pkg::INT_W-1:0] r_pos_integral;
    logic signed [DW-1:0]              r_pos_err_last, r_spd_err_last;
    logic signed [DW-1:0]              r_spd_err_before, r_spd_accum;

    // per-beat working registers
    logic signed [DW-1:0]              r_tgt, r_fb;
    logic signed [cpsp_pkg::RPM_W-1:0] r_rpm;
    logic signed [DW-1:0]              r_e, r_se, r_sref;
    logic signed [cpsp_pkg::INT_W-1:0] r_int;
    logic                              r_dead;
    logic                              r_neg;
    logic [cpsp_pkg::MAG_W-1:0]        r_mag;
    logic [DW-1:0]                     r_gain;
    logic [cpsp_pkg::PROD_W-1:0]       r_p, r_q;
    logic signed [AW-1:0]              r_acc;
    logic                              r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_kp      <= '0;
            r_pos_ki      <= '0;
            r_pos_kd      <= '0;
            r_pos_out_max <= '0;
            r_spd_kp      <= '0;
            r_spd_ki      <= '0;
            r_spd_kd      <= '0;
            r_spd_out_max <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                cpsp_pkg::REG_POS_KP:      r_pos_kp      <= i_cfg_data;
                cpsp_pkg::REG_POS_KI:      r_pos_ki      <= i_cfg_data;
                cpsp_pkg::REG_POS_KD:      r_pos_kd      <= i_cfg_data;
                cpsp_pkg::REG_POS_OUT_MAX: r_pos_out_max <= i_cfg_data[cpsp_pkg::LIM_W-1:0];
                cpsp_pkg::REG_SPD_KP:      r_spd_kp      <= i_cfg_data;
                cpsp_pkg::REG_SPD_KI:      r_spd_ki      <= i_cfg_data;
                cpsp_pkg::REG_SPD_KD:      r_spd_kd      <= i_cfg_data;
                cpsp_pkg::REG_SPD_OUT_MAX: r_spd_out_max <= i_cfg_data[cpsp_pkg::LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // outer error, integral and deadband
    logic signed [DW:0]                diff;
    logic [DW:0]                       abs_diff;
    logic signed [DW-1:0]              e_sat;
    logic signed [OW-1:0]              int_sum;

    assign diff     = (DW + 1)'(r_tgt) - (DW + 1)'(r_fb);
    assign abs_diff = diff[DW] ? (DW + 1)'(-diff) : (DW + 1)'(diff);
    assign e_sat    = cpsp_pkg::sat_data(OW'(diff));
    assign int_sum  = OW'(r_pos_integral) + OW'(e_sat);

    // gain term operand and gain
    logic signed [OW-1:0] opnd;
    logic [DW-1:0]        gain_sel;

    always_comb begin
        case (i_cmd.term)
            cpsp_pkg::TERM_POS_P: begin
                opnd     = OW'(r_e);
                gain_sel = r_pos_kp;
            end
            cpsp_pkg::TERM_POS_I: begin
                opnd     = OW'(r_int);
                gain_sel = r_pos_ki;
            end
            cpsp_pkg::TERM_POS_D: begin
                opnd     = OW'(r_e) - OW'(r_pos_err_last);
                gain_sel = r_pos_kd;
            end
            cpsp_pkg::TERM_SPD_P: begin
                opnd     = OW'(r_se) - OW'(r_spd_err_last);
                gain_sel = r_spd_kp;
            end
            cpsp_pkg::TERM_SPD_I: begin
                opnd     = OW'(r_se);
                gain_sel = r_spd_ki;
            end
            cpsp_pkg::TERM_SPD_D: begin
                opnd     = OW'(r_se) - (OW'(r_spd_err_last) <<< 1) + OW'(r_spd_err_before);
                gain_sel = r_spd_kd;
            end
            default: begin
                opnd     = '0;
                gain_sel = '0;
            end
        endcase
    end

    // single multiplier, high then low part of the magnitude
    logic [cpsp_pkg::HI_W-1:0]   mul_b;
    logic [cpsp_pkg::PROD_W-1:0] prod;

    assign mul_b = i_cmd.mul_hi ? r_mag[cpsp_pkg::MAG_W-1:cpsp_pkg::SPLIT]
                                : cpsp_pkg::HI_W'(r_mag[cpsp_pkg::SPLIT-1:0]);
    assign prod  = cpsp_pkg::PROD_W'(r_gain) * cpsp_pkg::PROD_W'(mul_b);

    // recombine, shift out the fraction, saturate, apply sign
    logic [cpsp_pkg::TSUM_W-1:0] t_raw, t_mag;
    logic signed [AW-1:0]        t_ext, term_val;

    assign t_raw = (cpsp_pkg::TSUM_W'(r_p) << cpsp_pkg::UP)
                 + cpsp_pkg::TSUM_W'(r_q >> cpsp_pkg::FRAC_BITS);
    assign t_mag = (r_p > cpsp_pkg::P_LIM)         ? cpsp_pkg::TERM_LIM :
                   (t_raw > cpsp_pkg::TERM_LIM)    ? cpsp_pkg::TERM_LIM : t_raw;
    assign t_ext    = signed'(AW'(t_mag));
    assign term_val = r_neg ? -t_ext : t_ext;

    // outer clamp and inner error
    logic signed [AW-1:0] plim, sref_c;
    logic signed [OW-1:0] se_diff;

    assign plim   = signed'(AW'(r_pos_out_max));
    assign sref_c = (r_acc > plim) ? plim : ((r_acc < -plim) ? -plim : r_acc);
    assign se_diff = OW'(sref_c) - (OW'(r_rpm) <<< cpsp_pkg::FRAC_BITS);

    // inner accumulator clamp and deadband override
    logic signed [AW-1:0] slim, acc_sum, acc_c;
    logic signed [DW-1:0] cmd_new;

    assign slim    = signed'(AW'(r_spd_out_max));
    assign acc_sum = AW'(r_spd_accum) + r_acc;
    assign acc_c   = (acc_sum > slim) ? slim : ((acc_sum < -slim) ? -slim : acc_sum);
    assign cmd_new = r_dead ? '0 : DW'(acc_c);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_tgt <= i_pos_target;
            r_fb  <= i_pos_feedback;
            r_rpm <= i_speed_feedback;
        end
        if (i_cmd.calc_err) begin
            r_e    <= e_sat;
            r_int  <= cpsp_pkg::sat_int(int_sum);
            r_dead <= (abs_diff < cpsp_pkg::DB_LIM);
        end
        if (i_cmd.load_opnd) begin
            r_neg  <= opnd[OW-1];
            r_mag  <= opnd[OW-1] ? cpsp_pkg::MAG_W'(-opnd) : cpsp_pkg::MAG_W'(opnd);
            r_gain <= gain_sel;
        end
        if (i_cmd.mul_hi) r_p <= prod;
        if (i_cmd.mul_lo) r_q <= prod;
        if (i_cmd.calc_err || i_cmd.calc_sref) begin
            r_acc <= '0;
        end else if (i_cmd.acc) begin
            r_acc <= r_acc + term_val;
        end
        if (i_cmd.calc_sref) begin
            r_sref <= DW'(sref_c);
            r_se   <= cpsp_pkg::sat_data(se_diff);
        end
        if (i_cmd.commit) begin
            o_speed_reference <= r_sref;
            o_drive_command   <= cmd_new;
            o_in_deadband     <= r_dead;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_integral   <= '0;
            r_pos_err_last   <= '0;
            r_spd_err_last   <= '0;
            r_spd_err_before <= '0;
            r_spd_accum      <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_pos_integral   <= r_int;
                r_pos_err_last   <= r_e;
                r_spd_err_before <= r_spd_err_last;
                r_spd_err_last   <= r_se;
                r_spd_accum      <= cmd_new;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_sts.out_free = !r_out_valid || !i_stall;

endmodule

@@ rtl/cascaded_position_speed_pid_core.sv @@
// Top level of the cascaded position/speed PID core.
// Cascaded position/speed servo, one control tick per input beat. An input beat is taken only
// while o_stall is low, and o_stall stays high from acceptance until the result is committed
// to the output register, so a new input is not taken before the previous beat is done. The
// single 32x25 gain multiplier is shared: after the error step, each of the six gain terms
// runs through operand, high product, low product and accumulate steps, with the outer clamp
// between the position and the speed terms and the commit at the end. The result sits in an
// output register, so a new beat may be accepted while the previous result is still stalled;
// commit waits for that register to free up. Gains and limits are written through the plain write
// port and are used by the next step that reads them; indexes beyond the register list are ignored.
module cascaded_position_speed_pid_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [cpsp_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [cpsp_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [cpsp_pkg::DATA_W-1:0]     i_pos_target,
    input  logic signed [cpsp_pkg::DATA_W-1:0]     i_pos_feedback,
    input  logic signed [cpsp_pkg::RPM_W-1:0]      i_speed_feedback,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [cpsp_pkg::DATA_W-1:0]     o_speed_reference,
    output logic signed [cpsp_pkg::DATA_W-1:0]     o_drive_command,
    output logic                                   o_in_deadband
);

    cpsp_pkg::t_dp_cmd cmd;
    cpsp_pkg::t_dp_sts sts;

    cpsp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    cpsp_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_pos_target      (i_pos_target),
        .i_pos_feedback    (i_pos_feedback),
        .i_speed_feedback  (i_speed_feedback),
        .i_stall           (i_stall),
        .o_valid           (o_valid),
        .o_speed_reference (o_speed_reference),
        .o_drive_command   (o_drive_command),
        .o_in_deadband     (o_in_deadband)
    );

    // deadband forces the command to zero
    a_deadband_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_in_deadband) |-> (o_drive_command == '0))
        else $error("drive command not zero in deadband");

    // an accepted beat keeps the input side stalled while it is worked on
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not stalled after accepting a beat");

    // a result only appears from a beat in progress
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result beat without work in progress");

endmodule
